// ===== hdl/scm_pkg.sv =====
// Package for the sparse column matrix store.
// Field, request and response types, sizes, codes and the saturation helper.
// No dependencies.
package scm_pkg;

    localparam int MAX_DIM  = 16;
    localparam int COL_CAP  = 16;
    localparam int DEPTH    = MAX_DIM * COL_CAP;
    localparam int DIM_W    = $clog2(MAX_DIM);
    localparam int CNT_W    = $clog2(COL_CAP + 1);
    localparam int CIDX_W   = $clog2(MAX_DIM + 1);
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam int CMD_W    = 3;
    localparam int ROW_W    = 6;
    localparam int VAL_W    = 32;
    localparam int SIZE_W   = 7;
    localparam int WIDE_W   = 64;
    localparam int QF       = 16;
    localparam int DIV_W    = VAL_W + QF;
    localparam int DIV_CW   = $clog2(DIV_W);

    localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(16);

    localparam logic [CMD_W-1:0] CMD_SET   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MUL   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DIV   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    localparam logic [2:0] EK_ENTRY = 3'd0;
    localparam logic [2:0] EK_RANGE = 3'd1;
    localparam logic [2:0] EK_FULL  = 3'd2;
    localparam logic [2:0] EK_DIVZ  = 3'd3;
    localparam logic [2:0] EK_LOAD  = 3'd4;
    localparam logic [2:0] EK_DIVOK = 3'd5;
    localparam logic [2:0] EK_ZERO  = 3'd6;
    localparam logic [2:0] EK_PROD  = 3'd7;

    localparam logic [1:0] WS_UPD   = 2'd0;
    localparam logic [1:0] WS_SHIFT = 2'd1;
    localparam logic [1:0] WS_NEW   = 2'd2;
    localparam logic [1:0] WS_DIV   = 2'd3;

    localparam logic signed [VAL_W-1:0]  Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0]  Q_MIN   = 32'sh8000_0000;
    localparam logic signed [WIDE_W-1:0] Q_MAX_W = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] Q_MIN_W = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [ROW_W-1:0]        row_index;
        logic [ROW_W-1:0]        col_index;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [ROW_W-1:0]        out_row;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
        logic [1:0]              status;
        logic                    structure_changed;
        logic                    values_changed;
    } t_rsp;

    typedef struct packed {
        logic              load;
        logic              mem_rd;
        logic              mem_wr;
        logic              use_req_col;
        logic [CIDX_W-1:0] col;
        logic [CNT_W-1:0]  slot;
        logic [1:0]        wr_src;
        logic              cnt_inc;
        logic              vec_wr;
        logic              acc_clr;
        logic              mul;
        logic              acc_upd;
        logic              div_start;
        logic              flags_clr;
        logic              emit;
        logic [2:0]        emit_kind;
        logic              last;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              range_bad;
        logic              div_zero;
        logic [CNT_W-1:0]  cnt_req;
        logic [CNT_W-1:0]  cnt_walk;
        logic [CIDX_W-1:0] size;
        logic              row_lt;
        logic              row_eq;
        logic              div_done;
    } t_dp_stat;

    function automatic logic signed [VAL_W-1:0] sat_q(input logic signed [WIDE_W-1:0] x);
        logic signed [VAL_W-1:0] r;
        if (x > Q_MAX_W) begin
            r = Q_MAX;
        end else if (x < Q_MIN_W) begin
            r = Q_MIN;
        end else begin
            r = VAL_W'(x);
        end
        return r;
    endfunction

endpackage

// ===== hdl/scm_div.sv =====
// Bit-serial divider: saturated truncating (num * 2^16) / den, Q16.16.
// One quotient bit per cycle. Depends on scm_pkg.
module scm_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [scm_pkg::VAL_W-1:0] i_num,
    input  logic signed [scm_pkg::VAL_W-1:0] i_den,
    output logic                            o_done,
    output logic signed [scm_pkg::VAL_W-1:0] o_quot
);
    import scm_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CW-1:0]       r_cnt;
    logic [DIV_W-1:0]        r_num;
    logic [VAL_W-1:0]        r_den;
    logic [VAL_W:0]          r_rem;
    logic [DIV_W-1:0]        r_quo;
    logic                    r_neg;
    logic signed [VAL_W-1:0] r_quot;

    logic [VAL_W:0]          num_abs;
    logic [VAL_W:0]          den_abs;
    logic [VAL_W:0]          rem_sh;
    logic                    ge;
    logic [VAL_W:0]          n_rem;
    logic [DIV_W-1:0]        n_quo;
    logic signed [VAL_W-1:0] n_quot;

    always_comb begin
        num_abs = i_num[VAL_W-1] ? -{i_num[VAL_W-1], i_num} : {1'b0, i_num};
        den_abs = i_den[VAL_W-1] ? -{i_den[VAL_W-1], i_den} : {1'b0, i_den};
        rem_sh  = {r_rem[VAL_W-1:0], r_num[DIV_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        n_rem   = ge ? rem_sh - {1'b0, r_den} : rem_sh;
        n_quo   = {r_quo[DIV_W-2:0], ge};
        if (!r_neg) begin
            n_quot = (|n_quo[DIV_W-1:VAL_W-1]) ? Q_MAX : n_quo[VAL_W-1:0];
        end else if ((|n_quo[DIV_W-1:VAL_W]) || (n_quo[VAL_W-1] && (|n_quo[VAL_W-2:0]))) begin
            n_quot = Q_MIN;
        end else begin
            n_quot = -n_quo[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == DIV_CW'(DIV_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {num_abs[VAL_W-1:0], QF'(0)};
            r_den <= den_abs[VAL_W-1:0];
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_num[VAL_W-1] ^ i_den[VAL_W-1];
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= n_quo;
            if (r_cnt == DIV_CW'(DIV_W - 1)) begin
                r_quot <= n_quot;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hdl/scm_dp.sv =====
// Datapath: entry memory, column counts, vector, accumulators, flags,
// multiplier, divider and response register. Depends on scm_pkg, scm_div.
module scm_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  scm_pkg::t_req               i_req,
    input  logic                        i_cfg_valid,
    input  logic [scm_pkg::SIZE_W-1:0]  i_cfg_data,
    input  scm_pkg::t_dp_cmd            i_cmd,
    output scm_pkg::t_dp_stat           o_stat,
    output logic                        o_valid,
    output scm_pkg::t_rsp               o_rsp
);
    import scm_pkg::*;

    t_req                    r_req;
    logic [SIZE_W-1:0]       r_size;
    logic [ROW_W+VAL_W-1:0]  r_mem [DEPTH];
    logic [ROW_W+VAL_W-1:0]  r_rd;
    logic [CNT_W-1:0]        r_cnt [MAX_DIM];
    logic signed [VAL_W-1:0] r_vec [MAX_DIM];
    logic signed [VAL_W-1:0] r_acc [MAX_DIM];
    logic                    r_sflag;
    logic                    r_vflag;
    logic signed [WIDE_W-1:0] r_prod;
    logic [DIM_W-1:0]        r_prow;
    logic                    r_pvalid;
    logic                    r_valid;
    t_rsp                    r_rsp;

    logic [CIDX_W-1:0]       size;
    logic [ROW_W-1:0]        rd_row;
    logic signed [VAL_W-1:0] rd_val;
    logic [DIM_W-1:0]        col_sel;
    logic [ADDR_W-1:0]       addr;
    logic signed [VAL_W-1:0] upd_val;
    logic [ROW_W-1:0]        wr_row;
    logic signed [VAL_W-1:0] wr_val;
    logic signed [VAL_W-1:0] p_sat;
    logic signed [VAL_W-1:0] acc_sum;
    logic                    n_sflag;
    logic                    n_vflag;
    logic                    row_bad;
    logic                    col_bad;
    logic                    div_done;
    logic signed [VAL_W-1:0] div_quot;
    t_rsp                    n_rsp;

    scm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (rd_val),
        .i_den   (r_req.value),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        if (r_size == '0) begin
            size = CIDX_W'(1);
        end else if (r_size > SIZE_W'(MAX_DIM)) begin
            size = CIDX_W'(MAX_DIM);
        end else begin
            size = CIDX_W'(r_size);
        end
        rd_row  = r_rd[ROW_W+VAL_W-1:VAL_W];
        rd_val  = r_rd[VAL_W-1:0];
        col_sel = i_cmd.use_req_col ? r_req.col_index[DIM_W-1:0] : i_cmd.col[DIM_W-1:0];
        addr    = ADDR_W'(col_sel * COL_CAP) + ADDR_W'(i_cmd.slot);
        row_bad = {1'b0, r_req.row_index} >= SIZE_W'(size);
        col_bad = {1'b0, r_req.col_index} >= SIZE_W'(size);

        case (r_req.cmd)
            CMD_SET: upd_val = r_req.value;
            CMD_ADD: upd_val = sat_q(WIDE_W'(rd_val) + WIDE_W'(r_req.value));
            default: upd_val = rd_val;
        endcase

        case (i_cmd.wr_src)
            WS_UPD: begin
                wr_row = r_req.row_index;
                wr_val = upd_val;
            end
            WS_SHIFT: begin
                wr_row = rd_row;
                wr_val = rd_val;
            end
            WS_NEW: begin
                wr_row = r_req.row_index;
                wr_val = (r_req.cmd == CMD_READ) ? '0 : r_req.value;
            end
            default: begin
                wr_row = rd_row;
                wr_val = div_quot;
            end
        endcase

        p_sat   = sat_q(r_prod >>> QF);
        acc_sum = sat_q(WIDE_W'(r_acc[r_prow]) + WIDE_W'(p_sat));

        n_sflag = r_sflag;
        n_vflag = r_vflag;
        if (i_cmd.flags_clr) begin
            n_sflag = 1'b0;
            n_vflag = 1'b0;
        end
        if (i_cmd.cnt_inc) begin
            n_sflag = 1'b1;
        end
        if (i_cmd.mem_wr && (i_cmd.wr_src != WS_SHIFT)
                && !(i_cmd.wr_src == WS_UPD && r_req.cmd == CMD_READ)) begin
            n_vflag = 1'b1;
        end

        n_rsp.out_row           = r_req.row_index;
        n_rsp.out_value         = '0;
        n_rsp.last              = i_cmd.last;
        n_rsp.status            = ST_OK;
        n_rsp.structure_changed = n_sflag;
        n_rsp.values_changed    = n_vflag;
        case (i_cmd.emit_kind)
            EK_ENTRY: n_rsp.out_value = wr_val;
            EK_RANGE: n_rsp.status = ST_RANGE;
            EK_FULL:  n_rsp.status = ST_FULL;
            EK_DIVZ: begin
                n_rsp.out_row   = '0;
                n_rsp.out_value = r_req.value;
                n_rsp.status    = ST_DIVZ;
            end
            EK_LOAD:  n_rsp.out_value = r_req.value;
            EK_DIVOK: begin
                n_rsp.out_row   = '0;
                n_rsp.out_value = r_req.value;
            end
            EK_PROD: begin
                n_rsp.out_row   = ROW_W'(i_cmd.col);
                n_rsp.out_value = r_acc[i_cmd.col[DIM_W-1:0]];
            end
            default: n_rsp.out_row = '0;
        endcase

        o_stat.cmd       = r_req.cmd;
        o_stat.range_bad = (r_req.cmd == CMD_LOAD) ? row_bad : (row_bad || col_bad);
        o_stat.div_zero  = (r_req.value == '0);
        o_stat.cnt_req   = r_cnt[r_req.col_index[DIM_W-1:0]];
        o_stat.cnt_walk  = (i_cmd.col < CIDX_W'(MAX_DIM)) ? r_cnt[i_cmd.col[DIM_W-1:0]] : '0;
        o_stat.size      = size;
        o_stat.row_lt    = rd_row < r_req.row_index;
        o_stat.row_eq    = rd_row == r_req.row_index;
        o_stat.div_done  = div_done;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.mem_wr) begin
            r_mem[addr] <= {wr_row, wr_val};
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[addr];
        end
        if (i_cmd.mul) begin
            r_prod   <= WIDE_W'(rd_val) * WIDE_W'(r_vec[i_cmd.col[DIM_W-1:0]]);
            r_prow   <= rd_row[DIM_W-1:0];
            r_pvalid <= {1'b0, rd_row} < SIZE_W'(size);
        end
        if (i_cmd.emit) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_RST;
            r_sflag <= 1'b0;
            r_vflag <= 1'b0;
            r_valid <= 1'b0;
            for (int i = 0; i < MAX_DIM; i++) begin
                r_cnt[i] <= '0;
                r_vec[i] <= '0;
                r_acc[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
            r_sflag <= n_sflag;
            r_vflag <= n_vflag;
            r_valid <= i_cmd.emit;
            if (i_cmd.cnt_inc) begin
                r_cnt[r_req.col_index[DIM_W-1:0]] <= r_cnt[r_req.col_index[DIM_W-1:0]] + 1'b1;
            end
            if (i_cmd.vec_wr) begin
                r_vec[r_req.row_index[DIM_W-1:0]] <= r_req.value;
            end
            if (i_cmd.acc_clr) begin
                for (int i = 0; i < MAX_DIM; i++) begin
                    r_acc[i] <= '0;
                end
            end else if (i_cmd.acc_upd && r_pvalid) begin
                r_acc[r_prow] <= acc_sum;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== hdl/scm_ctrl.sv =====
// Controller state machine: sequences search, insert shift, multiply walk,
// divide walk and result emission. Depends on scm_pkg.
module scm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  scm_pkg::t_dp_stat    i_stat,
    output scm_pkg::t_dp_cmd     o_cmd,
    output logic                 o_busy
);
    import scm_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_LOC_RD   = 4'd2;
    localparam logic [3:0] S_LOC_CHK  = 4'd3;
    localparam logic [3:0] S_UPD      = 4'd4;
    localparam logic [3:0] S_INS      = 4'd5;
    localparam logic [3:0] S_SH_RD    = 4'd6;
    localparam logic [3:0] S_SH_WR    = 4'd7;
    localparam logic [3:0] S_NEW      = 4'd8;
    localparam logic [3:0] S_MUL_RD   = 4'd9;
    localparam logic [3:0] S_MUL_MP   = 4'd10;
    localparam logic [3:0] S_MUL_AC   = 4'd11;
    localparam logic [3:0] S_PROD     = 4'd12;
    localparam logic [3:0] S_DIV_RD   = 4'd13;
    localparam logic [3:0] S_DIV_GO   = 4'd14;
    localparam logic [3:0] S_DIV_WAIT = 4'd15;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  n_k;
    logic [CNT_W-1:0]  r_j;
    logic [CNT_W-1:0]  n_j;
    logic [CIDX_W-1:0] r_c;
    logic [CIDX_W-1:0] n_c;
    t_dp_cmd           cmd;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_j     = r_j;
        n_c     = r_c;
        cmd     = '0;
        cmd.col  = r_c;
        cmd.slot = r_k;
        cmd.last = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                n_k     = '0;
                n_c     = '0;
                n_state = S_IDLE;
                case (i_stat.cmd)
                    CMD_SET, CMD_ADD, CMD_READ: begin
                        if (i_stat.range_bad) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EK_RANGE;
                        end else begin
                            n_state = S_LOC_RD;
                        end
                    end
                    CMD_LOAD: begin
                        cmd.emit = 1'b1;
                        if (i_stat.range_bad) begin
                            cmd.emit_kind = EK_RANGE;
                        end else begin
                            cmd.vec_wr    = 1'b1;
                            cmd.emit_kind = EK_LOAD;
                        end
                    end
                    CMD_MUL: begin
                        cmd.acc_clr = 1'b1;
                        n_state     = S_MUL_RD;
                    end
                    CMD_DIV: begin
                        if (i_stat.div_zero) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EK_DIVZ;
                        end else begin
                            n_state = S_DIV_RD;
                        end
                    end
                    CMD_CLEAR: begin
                        cmd.flags_clr = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = EK_ZERO;
                    end
                    default: begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = EK_ZERO;
                    end
                endcase
            end
            S_LOC_RD: begin
                cmd.use_req_col = 1'b1;
                if (r_k == i_stat.cnt_req) begin
                    n_state = S_INS;
                end else begin
                    cmd.mem_rd = 1'b1;
                    n_state    = S_LOC_CHK;
                end
            end
            S_LOC_CHK: begin
                if (i_stat.row_lt) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_LOC_RD;
                end else if (i_stat.row_eq) begin
                    n_state = S_UPD;
                end else begin
                    n_state = S_INS;
                end
            end
            S_UPD: begin
                cmd.use_req_col = 1'b1;
                cmd.mem_wr      = 1'b1;
                cmd.wr_src      = WS_UPD;
                cmd.emit        = 1'b1;
                cmd.emit_kind   = EK_ENTRY;
                n_state         = S_IDLE;
            end
            S_INS: begin
                if (i_stat.cnt_req >= CNT_W'(COL_CAP)) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_FULL;
                    n_state       = S_IDLE;
                end else begin
                    n_j     = i_stat.cnt_req;
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                cmd.use_req_col = 1'b1;
                if (r_j == r_k) begin
                    n_state = S_NEW;
                end else begin
                    cmd.slot   = r_j - 1'b1;
                    cmd.mem_rd = 1'b1;
                    n_state    = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.use_req_col = 1'b1;
                cmd.slot        = r_j;
                cmd.mem_wr      = 1'b1;
                cmd.wr_src      = WS_SHIFT;
                n_j             = r_j - 1'b1;
                n_state         = S_SH_RD;
            end
            S_NEW: begin
                cmd.use_req_col = 1'b1;
                cmd.mem_wr      = 1'b1;
                cmd.wr_src      = WS_NEW;
                cmd.cnt_inc     = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_kind   = EK_ENTRY;
                n_state         = S_IDLE;
            end
            S_MUL_RD: begin
                if (r_c == i_stat.size) begin
                    n_c     = '0;
                    n_state = S_PROD;
                end else if (r_k == i_stat.cnt_walk) begin
                    n_c = r_c + 1'b1;
                    n_k = '0;
                end else begin
                    cmd.mem_rd = 1'b1;
                    n_state    = S_MUL_MP;
                end
            end
            S_MUL_MP: begin
                cmd.mul = 1'b1;
                n_state = S_MUL_AC;
            end
            S_MUL_AC: begin
                cmd.acc_upd = 1'b1;
                n_k         = r_k + 1'b1;
                n_state     = S_MUL_RD;
            end
            S_PROD: begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = EK_PROD;
                cmd.last      = (r_c == i_stat.size - 1'b1);
                n_c           = r_c + 1'b1;
                if (cmd.last) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV_RD: begin
                if (r_c == CIDX_W'(MAX_DIM)) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_DIVOK;
                    n_state       = S_IDLE;
                end else if (r_k == i_stat.cnt_walk) begin
                    n_c = r_c + 1'b1;
                    n_k = '0;
                end else begin
                    cmd.mem_rd = 1'b1;
                    n_state    = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    cmd.mem_wr = 1'b1;
                    cmd.wr_src = WS_DIV;
                    n_k        = r_k + 1'b1;
                    n_state    = S_DIV_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_j     <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_j     <= n_j;
            r_c     <= n_c;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hdl/sparse_column_matrix_store.sv =====
// Sparse column matrix store, top level.
// Joins scm_ctrl and scm_dp. Depends on scm_pkg.
//
// A request is taken when start is high and busy is low; busy then stays
// high until the last result of the request has been put out. Results
// appear for one cycle each with o_valid and cannot be held off. Set, add
// and read search the column one entry at a time, and an insert then
// moves each later entry up one slot; a full column is reported after
// its search. Load, clear, range errors and divide by zero are answered
// from the decode state. Multiply reads, multiplies and accumulates each
// stored entry in the active columns in turn, then puts out one result
// per row on consecutive cycles. Divide runs the bit-serial divider once
// per stored entry. The entry memory has a single port and is walked one
// entry at a time. No pass is needed after reset.
module sparse_column_matrix_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  scm_pkg::t_req              i_req,
    output logic                       o_valid,
    output scm_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [scm_pkg::SIZE_W-1:0] i_cfg_data
);
    import scm_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    scm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    scm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

    assign o_cfg_ready = 1'b1;

endmodule

// ===== hdl/scm_checker.sv =====
// Port-level checks for the sparse column matrix store, bound to the top.
// Depends on scm_pkg and sparse_column_matrix_store.
module scm_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          busy,
    input  logic          o_valid,
    input  scm_pkg::t_rsp o_rsp
);
    import scm_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !busy && !o_valid)
        else $error("not idle after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.last |-> !busy)
        else $error("busy after final result");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.last |-> busy)
        else $error("results pending but block idle");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a request in progress");

endmodule

bind sparse_column_matrix_store scm_checker u_scm_checker (.*);

// ===== tb/sparse_column_matrix_store_tb.sv =====
// Testbench for sparse_column_matrix_store: directed and random requests,
// results checked against a built-in predictor of the column store.
// Depends on scm_pkg and the block's RTL.
`timescale 1ns / 100ps

class scm_scoreboard;
    scm_pkg::t_rsp expected_rsps[$];
    int            errors;
    logic [6:0]    size_reg;
    logic [5:0]    ent_row [scm_pkg::DEPTH];
    int            ent_val [scm_pkg::DEPTH];
    int unsigned   col_cnt [scm_pkg::MAX_DIM];
    int            vec     [scm_pkg::MAX_DIM];
    bit            struct_flag;
    bit            value_flag;

    function new();
        errors = 0;
        size_reg = scm_pkg::SIZE_RST;
        struct_flag = 0;
        value_flag = 0;
        foreach (col_cnt[i]) col_cnt[i] = 0;
        foreach (vec[i]) vec[i] = 0;
    endfunction

    function int clip(longint x);
        if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (x < -64'sh8000_0000) return 32'sh8000_0000;
        return int'(x);
    endfunction

    function int unsigned dim();
        if (size_reg < 1) return 1;
        if (size_reg > scm_pkg::MAX_DIM) return scm_pkg::MAX_DIM;
        return size_reg;
    endfunction

    function void push(logic [5:0] row, int val, bit last, logic [1:0] st);
        scm_pkg::t_rsp r;
        r.out_row = row;
        r.out_value = val;
        r.last = last;
        r.status = st;
        r.structure_changed = struct_flag;
        r.values_changed = value_flag;
        expected_rsps.push_back(r);
    endfunction

    function void note_request(scm_pkg::t_req q);
        int unsigned n, col, row, pos, base, k, c;
        int          res;
        int          acc [scm_pkg::MAX_DIM];
        bit          found;
        longint      prod;
        n = dim();
        row = q.row_index;
        col = q.col_index;
        case (q.cmd)
            scm_pkg::CMD_SET, scm_pkg::CMD_ADD, scm_pkg::CMD_READ: begin
                if (row >= n || col >= n) begin
                    push(row, 0, 1, scm_pkg::ST_RANGE);
                    return;
                end
                base = col * scm_pkg::COL_CAP;
                pos = 0;
                while (pos < col_cnt[col] && ent_row[base + pos] < row) pos++;
                found = pos < col_cnt[col] && ent_row[base + pos] == row;
                if (!found && col_cnt[col] >= scm_pkg::COL_CAP) begin
                    push(row, 0, 1, scm_pkg::ST_FULL);
                    return;
                end
                if (found) begin
                    if (q.cmd == scm_pkg::CMD_SET) begin
                        ent_val[base + pos] = q.value;
                        value_flag = 1;
                    end else if (q.cmd == scm_pkg::CMD_ADD) begin
                        ent_val[base + pos] =
                            clip(longint'(ent_val[base + pos]) + longint'(q.value));
                        value_flag = 1;
                    end
                    res = ent_val[base + pos];
                end else begin
                    res = (q.cmd == scm_pkg::CMD_READ) ? 0 : q.value;
                    for (k = col_cnt[col]; k > pos; k--) begin
                        ent_row[base + k] = ent_row[base + k - 1];
                        ent_val[base + k] = ent_val[base + k - 1];
                    end
                    ent_row[base + pos] = row;
                    ent_val[base + pos] = res;
                    col_cnt[col]++;
                    struct_flag = 1;
                    value_flag = 1;
                end
                push(row, res, 1, scm_pkg::ST_OK);
            end
            scm_pkg::CMD_LOAD: begin
                if (row >= n) begin
                    push(row, 0, 1, scm_pkg::ST_RANGE);
                    return;
                end
                vec[row] = q.value;
                push(row, q.value, 1, scm_pkg::ST_OK);
            end
            scm_pkg::CMD_MUL: begin
                foreach (acc[i]) acc[i] = 0;
                for (c = 0; c < n; c++) begin
                    for (k = 0; k < col_cnt[c]; k++) begin
                        if (ent_row[c * scm_pkg::COL_CAP + k] < n) begin
                            prod = longint'(ent_val[c * scm_pkg::COL_CAP + k])
                                   * longint'(vec[c]);
                            prod = prod >>> 16;
                            acc[ent_row[c * scm_pkg::COL_CAP + k]] =
                                clip(longint'(acc[ent_row[c * scm_pkg::COL_CAP + k]])
                                     + longint'(clip(prod)));
                        end
                    end
                end
                for (k = 0; k < n; k++) push(k, acc[k], k + 1 == n, scm_pkg::ST_OK);
            end
            scm_pkg::CMD_DIV: begin
                if (q.value == 0) begin
                    push(0, 0, 1, scm_pkg::ST_DIVZ);
                    return;
                end
                for (c = 0; c < scm_pkg::MAX_DIM; c++) begin
                    for (k = 0; k < col_cnt[c]; k++) begin
                        ent_val[c * scm_pkg::COL_CAP + k] = clip(
                            (longint'(ent_val[c * scm_pkg::COL_CAP + k]) * 65536)
                            / longint'(q.value));
                        value_flag = 1;
                    end
                end
                push(0, q.value, 1, scm_pkg::ST_OK);
            end
            scm_pkg::CMD_CLEAR: begin
                struct_flag = 0;
                value_flag = 0;
                push(0, 0, 1, scm_pkg::ST_OK);
            end
            default: push(0, 0, 1, scm_pkg::ST_OK);
        endcase
    endfunction

    function void check_result(scm_pkg::t_rsp got);
        scm_pkg::t_rsp exp;
        if (expected_rsps.size() == 0) begin
            $error("result with nothing expected: row %0d value %0d",
                   got.out_row, got.out_value);
            errors++;
            return;
        end
        exp = expected_rsps.pop_front();
        if (got.out_row !== exp.out_row) begin
            $error("out_row: expected %0d got %0d", exp.out_row, got.out_row);
            errors++;
        end
        if (got.out_value !== exp.out_value) begin
            $error("out_value: expected %0d got %0d", exp.out_value, got.out_value);
            errors++;
        end
        if (got.last !== exp.last) begin
            $error("last: expected %0d got %0d", exp.last, got.last);
            errors++;
        end
        if (got.status !== exp.status) begin
            $error("status: expected %0d got %0d", exp.status, got.status);
            errors++;
        end
        if (got.structure_changed !== exp.structure_changed) begin
            $error("structure_changed: expected %0d got %0d",
                   exp.structure_changed, got.structure_changed);
            errors++;
        end
        if (got.values_changed !== exp.values_changed) begin
            $error("values_changed: expected %0d got %0d",
                   exp.values_changed, got.values_changed);
            errors++;
        end
    endfunction
endclass

module sparse_column_matrix_store_tb;
    import scm_pkg::*;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 start = 0;
    logic                 busy;
    t_req                 i_req = '0;
    logic                 o_valid;
    t_rsp                 o_rsp;
    logic                 i_cfg_valid = 0;
    logic                 o_cfg_ready;
    logic [SIZE_W-1:0]    i_cfg_data = '0;

    scm_scoreboard sb = new();
    int            idle_pct = 0;

    sparse_column_matrix_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_rsp);
    end

    task automatic send_request(logic [2:0] cmd, logic [5:0] row, logic [5:0] col,
                                logic [31:0] val);
        t_req q;
        q.cmd = cmd;
        q.row_index = row;
        q.col_index = col;
        q.value = val;
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_req <= q;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_request(q);
    endtask

    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (sb.expected_rsps.size() != 0 || busy) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] sz);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= sz;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        i_cfg_valid <= 0;
        sb.size_reg = sz;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    task automatic random_requests(int count);
        int unsigned n, pick;
        logic [5:0]  row, col;
        logic [31:0] val;
        repeat (count) begin
            n = sb.dim();
            row = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(n - 1));
            col = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(n - 1));
            val = rand_value();
            pick = $urandom_range(99);
            if (pick < 28) send_request(CMD_SET, row, col, val);
            else if (pick < 50) send_request(CMD_ADD, row, col, val);
            else if (pick < 62) send_request(CMD_READ, row, col, val);
            else if (pick < 80) send_request(CMD_LOAD, row, col, val);
            else if (pick < 90) send_request(CMD_MUL, row, col, val);
            else if (pick < 93) begin
                case ($urandom_range(3))
                    0: val = 32'd0;
                    1: val = 32'hFFFF_FFFF;
                    2: val = 32'h0001_0000;
                    default: val = $urandom;
                endcase
                send_request(CMD_DIV, row, col, val);
            end else if (pick < 97) send_request(CMD_CLEAR, row, col, val);
            else send_request(3'd7, row, col, val);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_request(CMD_READ,  6'd3,  6'd2,  32'h1234_5678);
        send_request(CMD_SET,   6'd0,  6'd0,  32'h7FFF_FFFF);
        send_request(CMD_SET,   6'd15, 6'd15, 32'h8000_0000);
        send_request(CMD_SET,   6'd1,  6'd0,  32'h0002_0000);
        send_request(CMD_ADD,   6'd0,  6'd0,  32'h0000_0001);
        send_request(CMD_ADD,   6'd15, 6'd15, 32'hFFFF_FFFF);
        send_request(CMD_ADD,   6'd5,  6'd0,  32'hFFFE_0000);
        send_request(CMD_READ,  6'd1,  6'd0,  32'h0);
        send_request(CMD_LOAD,  6'd0,  6'd0,  32'h7FFF_FFFF);
        send_request(CMD_LOAD,  6'd15, 6'd0,  32'h8000_0000);
        send_request(CMD_LOAD,  6'd16, 6'd0,  32'h1);
        send_request(CMD_MUL,   6'd0,  6'd0,  32'h0);
        send_request(CMD_SET,   6'd63, 6'd0,  32'h1);
        send_request(CMD_SET,   6'd0,  6'd63, 32'h1);
        send_request(CMD_CLEAR, 6'd0,  6'd0,  32'h0);
        send_request(CMD_DIV,   6'd0,  6'd0,  32'h0);
        send_request(CMD_DIV,   6'd0,  6'd0,  32'hFFFF_FFFF);
        send_request(CMD_DIV,   6'd0,  6'd0,  32'h0003_0000);
        send_request(3'd7,      6'd63, 6'd63, 32'hFFFF_FFFF);
        send_request(CMD_LOAD,  6'd0,  6'd0,  32'h0001_8000);
        send_request(CMD_MUL,   6'd0,  6'd0,  32'h0);

        idle_pct = 37;
        write_size(7'd127);
        random_requests(90);
        write_size(7'd0);
        random_requests(15);
        write_size(7'd1);
        random_requests(10);
        idle_pct = 78;
        write_size(7'd5);
        random_requests(60);
        idle_pct = 0;
        write_size(7'd64);
        random_requests(90);
        write_size(SIZE_RST);
        random_requests(15);

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_rsps.size() == 0) begin
            $display("sparse_column_matrix_store regression: pass");
        end else begin
            $display("sparse_column_matrix_store regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("sparse_column_matrix_store regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/scm_pkg.sv
hdl/scm_div.sv
hdl/scm_dp.sv
hdl/scm_ctrl.sv
hdl/sparse_column_matrix_store.sv
hdl/scm_checker.sv
tb/sparse_column_matrix_store_tb.sv
